>>> sv/thwsm_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and arithmetic helpers for the wheel speed mixer
package thwsm_pkg;

   localparam int SPEED_W   = 10;
   localparam int OUT_W     = 11;
   localparam int TILT_W    = 8;
   localparam int HEAD_W    = 12;
   localparam int RANGE_W   = 16;
   localparam int DZ_W      = 7;
   localparam int GAIN_W    = 12;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int SAT_W     = 19;

   // reciprocal of 90 in Q24, exact for every tilt times speed product
   localparam int RECIP_SHIFT  = 24;
   localparam int RECIP_W      = 18;
   localparam int SCALE_W      = SPEED_W + RECIP_W;
   localparam int RECIP_90_VAL = ((2 ** RECIP_SHIFT) + 89) / 90;
   localparam logic [RECIP_W-1:0] RECIP_90 = RECIP_W'(RECIP_90_VAL);

   localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST = SPEED_W'(900);
   localparam logic [SPEED_W-1:0] SPEED_FLOOR_RST = SPEED_W'(150);
   localparam logic [DZ_W-1:0]    DEAD_ZONE_RST   = DZ_W'(5);
   localparam logic [RANGE_W-1:0] STOP_RANGE_RST  = RANGE_W'(25);
   localparam logic [GAIN_W-1:0]  KP_GAIN_RST     = GAIN_W'(768);
   localparam logic [GAIN_W-1:0]  KD_GAIN_RST     = GAIN_W'(26);
   localparam logic [SCALE_W-1:0] SCALE_RST       = SCALE_W'(900 * RECIP_90_VAL);

   localparam logic [RANGE_W-1:0] RANGE_NONE = {RANGE_W{1'b1}};

   localparam logic signed [HEAD_W:0] HALF_TURN = (HEAD_W + 1)'(1800);
   localparam logic signed [HEAD_W:0] FULL_TURN = (HEAD_W + 1)'(3600);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPEED_LIMIT = 3'd0,
      CSR_SPEED_FLOOR = 3'd1,
      CSR_DEAD_ZONE   = 3'd2,
      CSR_STOP_RANGE  = 3'd3,
      CSR_KP_GAIN     = 3'd4,
      CSR_KD_GAIN     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [SPEED_W-1:0] speed_limit;
      logic [SPEED_W-1:0] speed_floor;
      logic [DZ_W-1:0]    dead_zone;
      logic [RANGE_W-1:0] stop_range;
      logic [GAIN_W-1:0]  kp_gain;
      logic [GAIN_W-1:0]  kd_gain;
      logic [SCALE_W-1:0] speed_scale;
   } cfg_type;

   // magnitude of a signed tilt, -128 gives 128
   function automatic logic [TILT_W-1:0] tilt_mag(input logic [TILT_W-1:0] deg);
      tilt_mag = deg[TILT_W-1] ? (~deg + TILT_W'(1)) : deg;
   endfunction

   // floor(mag * speed_limit / 90) through the prescaled reciprocal
   function automatic logic [OUT_W-1:0] tilt_scale(input logic [TILT_W-1:0] mag,
                                                   input logic [SCALE_W-1:0] scale);
      logic [TILT_W+SCALE_W-1:0] prod;
      prod = {{SCALE_W{1'b0}}, mag} * {{TILT_W{1'b0}}, scale};
      tilt_scale = prod[RECIP_SHIFT +: OUT_W];
   endfunction

   // symmetric clamp to +-lim
   function automatic logic signed [OUT_W-1:0] sat_lim(input logic signed [SAT_W-1:0] v,
                                                       input logic [SPEED_W-1:0] lim);
      logic signed [SAT_W-1:0] lim_s;
      lim_s = $signed({{(SAT_W - SPEED_W){1'b0}}, lim});
      if (v > lim_s) begin
         sat_lim = lim_s[OUT_W-1:0];
      end else if (v < -lim_s) begin
         sat_lim = -lim_s[OUT_W-1:0];
      end else begin
         sat_lim = v[OUT_W-1:0];
      end
   endfunction

endpackage

>>> sv/thwsm_ifs.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for sample, result and register words
interface thwsm_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [thwsm_pkg::TILT_W-1:0]     pitch_deg;
   logic signed [thwsm_pkg::TILT_W-1:0]     roll_deg;
   logic        [thwsm_pkg::HEAD_W-1:0]     target_heading;
   logic        [thwsm_pkg::HEAD_W-1:0]     actual_heading;
   logic        [thwsm_pkg::RANGE_W-1:0]    obstacle_range;
   logic                                    heading_mode;

   modport source (output valid, pitch_deg, roll_deg, target_heading, actual_heading,
                   obstacle_range, heading_mode, input ready);
   modport sink   (input valid, pitch_deg, roll_deg, target_heading, actual_heading,
                   obstacle_range, heading_mode, output ready);
endinterface

interface thwsm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [thwsm_pkg::OUT_W-1:0]  left_speed;
   logic signed [thwsm_pkg::OUT_W-1:0]  right_speed;
   logic signed [thwsm_pkg::OUT_W-1:0]  drive_speed;
   logic signed [thwsm_pkg::OUT_W-1:0]  turn_speed;

   modport source (output valid, left_speed, right_speed, drive_speed, turn_speed,
                   input ready);
   modport sink   (input valid, left_speed, right_speed, drive_speed, turn_speed,
                   output ready);
endinterface

interface thwsm_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [thwsm_pkg::CSR_IDX_W-1:0]      index;
   logic [thwsm_pkg::CSR_DAT_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/thwsm_csr.sv
`timescale 1ns / 1ps
// configuration registers with the prescaled tilt reciprocal
module thwsm_csr (
   input  logic               clock,
   input  logic               reset,
   thwsm_csr_if.sink          csr_bus,
   output thwsm_pkg::cfg_type cfg
);

   thwsm_pkg::cfg_type cfg_ff;
   thwsm_pkg::cfg_type cfg_in;
   logic               wr;

   assign csr_bus.ready = 1'b1;
   assign wr            = csr_bus.valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (thwsm_pkg::csr_index_type'(csr_bus.index))
            thwsm_pkg::CSR_SPEED_LIMIT: begin
               cfg_in.speed_limit = csr_bus.data[thwsm_pkg::SPEED_W-1:0];
               cfg_in.speed_scale =
                  {{(thwsm_pkg::SCALE_W - thwsm_pkg::SPEED_W){1'b0}},
                   csr_bus.data[thwsm_pkg::SPEED_W-1:0]}
                  * {{(thwsm_pkg::SCALE_W - thwsm_pkg::RECIP_W){1'b0}}, thwsm_pkg::RECIP_90};
            end
            thwsm_pkg::CSR_SPEED_FLOOR: begin
               cfg_in.speed_floor = csr_bus.data[thwsm_pkg::SPEED_W-1:0];
            end
            thwsm_pkg::CSR_DEAD_ZONE: begin
               cfg_in.dead_zone = csr_bus.data[thwsm_pkg::DZ_W-1:0];
            end
            thwsm_pkg::CSR_STOP_RANGE: begin
               cfg_in.stop_range = csr_bus.data[thwsm_pkg::RANGE_W-1:0];
            end
            thwsm_pkg::CSR_KP_GAIN: begin
               cfg_in.kp_gain = csr_bus.data[thwsm_pkg::GAIN_W-1:0];
            end
            thwsm_pkg::CSR_KD_GAIN: begin
               cfg_in.kd_gain = csr_bus.data[thwsm_pkg::GAIN_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_limit <= thwsm_pkg::SPEED_LIMIT_RST;
         cfg_ff.speed_floor <= thwsm_pkg::SPEED_FLOOR_RST;
         cfg_ff.dead_zone   <= thwsm_pkg::DEAD_ZONE_RST;
         cfg_ff.stop_range  <= thwsm_pkg::STOP_RANGE_RST;
         cfg_ff.kp_gain     <= thwsm_pkg::KP_GAIN_RST;
         cfg_ff.kd_gain     <= thwsm_pkg::KD_GAIN_RST;
         cfg_ff.speed_scale <= thwsm_pkg::SCALE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/thwsm_drive.sv
`timescale 1ns / 1ps
// drive speed from pitch: dead zone, minimum, limit and obstacle stop
module thwsm_drive (
   input  thwsm_pkg::cfg_type                      cfg,
   input  logic signed [thwsm_pkg::TILT_W-1:0]     pitch_deg,
   input  logic        [thwsm_pkg::RANGE_W-1:0]    obstacle_range,
   output logic signed [thwsm_pkg::OUT_W-1:0]      drive_speed
);

   logic [thwsm_pkg::TILT_W-1:0] mag;
   logic [thwsm_pkg::OUT_W-1:0]  scaled;
   logic [thwsm_pkg::OUT_W-1:0]  m_dz;
   logic [thwsm_pkg::OUT_W-1:0]  m_min;
   logic [thwsm_pkg::OUT_W-1:0]  m_sat;
   logic [thwsm_pkg::OUT_W-1:0]  min_ext;
   logic [thwsm_pkg::OUT_W-1:0]  max_ext;
   logic                         stop;

   assign mag     = thwsm_pkg::tilt_mag(pitch_deg);
   assign scaled  = thwsm_pkg::tilt_scale(mag, cfg.speed_scale);
   assign min_ext = {1'b0, cfg.speed_floor};
   assign max_ext = {1'b0, cfg.speed_limit};

   always_comb begin
      m_dz  = (mag < {1'b0, cfg.dead_zone}) ? '0 : scaled;
      m_min = ((m_dz != '0) && (m_dz < min_ext)) ? min_ext : m_dz;
      m_sat = (m_min > max_ext) ? max_ext : m_min;
      stop  = (obstacle_range < cfg.stop_range) && (obstacle_range != thwsm_pkg::RANGE_NONE)
              && !pitch_deg[thwsm_pkg::TILT_W-1];
      if (stop) begin
         drive_speed = '0;
      end else if (pitch_deg[thwsm_pkg::TILT_W-1]) begin
         drive_speed = $signed(~m_sat + thwsm_pkg::OUT_W'(1));
      end else begin
         drive_speed = $signed(m_sat);
      end
   end

endmodule

>>> sv/thwsm_turn.sv
`timescale 1ns / 1ps
// turn speed from roll or from pd on the wrapped heading error
module thwsm_turn (
   input  thwsm_pkg::cfg_type                      cfg,
   input  logic signed [thwsm_pkg::TILT_W-1:0]     roll_deg,
   input  logic        [thwsm_pkg::HEAD_W-1:0]     target_heading,
   input  logic        [thwsm_pkg::HEAD_W-1:0]     actual_heading,
   input  logic                                    heading_mode,
   input  logic signed [thwsm_pkg::HEAD_W-1:0]     last_err,
   output logic signed [thwsm_pkg::HEAD_W-1:0]     head_err,
   output logic signed [thwsm_pkg::OUT_W-1:0]      turn_speed
);

   localparam int EW = thwsm_pkg::HEAD_W + 1;
   localparam int GW = thwsm_pkg::GAIN_W + 1;
   localparam int PW = GW + thwsm_pkg::HEAD_W;
   localparam int DW = GW + EW;
   localparam int AW = DW + 1;

   logic [thwsm_pkg::TILT_W-1:0]  mag;
   logic [thwsm_pkg::OUT_W-1:0]   scaled;
   logic [thwsm_pkg::OUT_W-1:0]   max_ext;
   logic [thwsm_pkg::OUT_W-1:0]   roll_m;
   logic signed [thwsm_pkg::OUT_W-1:0] roll_turn;
   logic signed [EW-1:0]          diff;
   logic signed [EW-1:0]          wrapped;
   logic signed [EW-1:0]          derr;
   logic signed [PW-1:0]          p_term;
   logic signed [DW-1:0]          d_term;
   logic signed [AW-1:0]          acc;
   logic signed [thwsm_pkg::OUT_W-1:0] pd_turn;

   assign mag     = thwsm_pkg::tilt_mag(roll_deg);
   assign scaled  = thwsm_pkg::tilt_scale(mag, cfg.speed_scale);
   assign max_ext = {1'b0, cfg.speed_limit};

   always_comb begin
      if (mag < {1'b0, cfg.dead_zone}) begin
         roll_m = '0;
      end else begin
         roll_m = (scaled > max_ext) ? max_ext : scaled;
      end
      roll_turn = roll_deg[thwsm_pkg::TILT_W-1] ? $signed(~roll_m + thwsm_pkg::OUT_W'(1))
                                                : $signed(roll_m);
   end

   always_comb begin
      diff = $signed({1'b0, target_heading}) - $signed({1'b0, actual_heading});
      priority if (diff > thwsm_pkg::HALF_TURN) begin
         wrapped = diff - thwsm_pkg::FULL_TURN;
      end else if (diff < -thwsm_pkg::HALF_TURN) begin
         wrapped = diff + thwsm_pkg::FULL_TURN;
      end else begin
         wrapped = diff;
      end
   end

   assign head_err = wrapped[thwsm_pkg::HEAD_W-1:0];
   assign derr     = {head_err[thwsm_pkg::HEAD_W-1], head_err}
                   - {last_err[thwsm_pkg::HEAD_W-1], last_err};
   assign p_term   = $signed({1'b0, cfg.kp_gain}) * head_err;
   assign d_term   = $signed({1'b0, cfg.kd_gain}) * derr;
   assign acc      = {{(AW - PW){p_term[PW-1]}}, p_term} + {d_term[DW-1], d_term};
   // arithmetic shift right by 8 is a floor divide
   assign pd_turn  = thwsm_pkg::sat_lim(acc[AW-1:8], cfg.speed_limit);

   assign turn_speed = heading_mode ? pd_turn : roll_turn;

endmodule

>>> sv/tilt_heading_wheel_speed_mixer.sv
`timescale 1ns / 1ps
// top level: sample register, mixer logic and result register
// an accepted sample word passes through the sample register, then the result register, to rsp_bus
// throughput: one sample word per cycle while rsp_bus is ready, set by the single input and result register pair
// a stalled result register still lets one more sample word wait in the input register
// reset: synchronous, clears both valid flags and the stored heading error,
// and loads the register defaults (max 900, min 150, dead zone 5, stop 25, kp 768, kd 26)
module tilt_heading_wheel_speed_mixer (
   input  logic        clock,
   input  logic        reset,
   thwsm_req_if.sink   req_bus,
   thwsm_rsp_if.source rsp_bus,
   thwsm_csr_if.sink   csr_bus
);

   thwsm_pkg::cfg_type cfg;

   logic                                    s1_valid_ff;
   logic signed [thwsm_pkg::TILT_W-1:0]     pitch_ff;
   logic signed [thwsm_pkg::TILT_W-1:0]     roll_ff;
   logic        [thwsm_pkg::HEAD_W-1:0]     target_ff;
   logic        [thwsm_pkg::HEAD_W-1:0]     meas_ff;
   logic        [thwsm_pkg::RANGE_W-1:0]    range_ff;
   logic                                    mode_ff;

   logic signed [thwsm_pkg::HEAD_W-1:0]     last_err_ff;
   logic signed [thwsm_pkg::HEAD_W-1:0]     head_err;

   logic                                    rsp_valid_ff;
   logic signed [thwsm_pkg::OUT_W-1:0]      left_ff;
   logic signed [thwsm_pkg::OUT_W-1:0]      right_ff;
   logic signed [thwsm_pkg::OUT_W-1:0]      drive_ff;
   logic signed [thwsm_pkg::OUT_W-1:0]      turn_ff;

   logic signed [thwsm_pkg::OUT_W-1:0]      drive_speed;
   logic signed [thwsm_pkg::OUT_W-1:0]      turn_speed;
   logic signed [thwsm_pkg::OUT_W-1:0]      left_in;
   logic signed [thwsm_pkg::OUT_W-1:0]      right_in;
   logic signed [thwsm_pkg::OUT_W:0]        diff_sum;
   logic signed [thwsm_pkg::OUT_W:0]        add_sum;

   logic advance;
   logic take;

   thwsm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   thwsm_drive u_drive (
      .cfg            (cfg),
      .pitch_deg      (pitch_ff),
      .obstacle_range (range_ff),
      .drive_speed    (drive_speed)
   );

   thwsm_turn u_turn (
      .cfg            (cfg),
      .roll_deg       (roll_ff),
      .target_heading (target_ff),
      .actual_heading (meas_ff),
      .heading_mode   (mode_ff),
      .last_err       (last_err_ff),
      .head_err       (head_err),
      .turn_speed     (turn_speed)
   );

   assign advance       = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   assign diff_sum = {drive_speed[thwsm_pkg::OUT_W-1], drive_speed}
                   - {turn_speed[thwsm_pkg::OUT_W-1], turn_speed};
   assign add_sum  = {drive_speed[thwsm_pkg::OUT_W-1], drive_speed}
                   + {turn_speed[thwsm_pkg::OUT_W-1], turn_speed};
   assign left_in  = thwsm_pkg::sat_lim(
      {{(thwsm_pkg::SAT_W - thwsm_pkg::OUT_W - 1){diff_sum[thwsm_pkg::OUT_W]}}, diff_sum},
      cfg.speed_limit);
   assign right_in = thwsm_pkg::sat_lim(
      {{(thwsm_pkg::SAT_W - thwsm_pkg::OUT_W - 1){add_sum[thwsm_pkg::OUT_W]}}, add_sum},
      cfg.speed_limit);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_err_ff  <= '0;
      end else begin
         if (take) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance && mode_ff) begin
            last_err_ff <= head_err;
         end
      end
   end

   // sample word register
   always_ff @(posedge clock) begin
      if (take) begin
         pitch_ff  <= req_bus.pitch_deg;
         roll_ff   <= req_bus.roll_deg;
         target_ff <= req_bus.target_heading;
         meas_ff   <= req_bus.actual_heading;
         range_ff  <= req_bus.obstacle_range;
         mode_ff   <= req_bus.heading_mode;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (advance) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         drive_ff <= drive_speed;
         turn_ff  <= turn_speed;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.left_speed  = left_ff;
   assign rsp_bus.right_speed = right_ff;
   assign rsp_bus.drive_speed = drive_ff;
   assign rsp_bus.turn_speed  = turn_ff;

`ifndef ASSERT_OFF
   a_no_turn_same_speed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (turn_ff == '0)) |-> ((left_ff == drive_ff) && (right_ff == drive_ff)))
      else $error("zero turn but wheel speeds differ from drive");

   a_spin_symmetric: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (drive_ff == '0)) |-> (left_ff == -right_ff))
      else $error("spin in place is not symmetric");

   a_err_wrapped: assert property (@(posedge clock) disable iff (reset)
      (last_err_ff <= 12'sd1800) && (last_err_ff >= -12'sd1800))
      else $error("stored heading error outside half turn");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("sample word taken while both registers are held");
`endif

endmodule
